// ===== design/cbor_item_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// CBOR item encoder assertion macros
// Shared assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef CBOR_ITEM_ENCODER_DEFINES_SVH
`define CBOR_ITEM_ENCODER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CIE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define CIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cie_pkg.sv =====
// ----------------------------------------------------------------------------
// CBOR item encoder package
// Command codes, queue entry type and the float64 to float32 narrowing.
// ----------------------------------------------------------------------------
package cie_pkg;

  typedef enum logic [3:0] {
    CMD_UINT  = 4'd0,
    CMD_SINT  = 4'd1,
    CMD_BYTES = 4'd2,
    CMD_TEXT  = 4'd3,
    CMD_TAG   = 4'd4,
    CMD_F32   = 4'd5,
    CMD_F64   = 4'd6,
    CMD_BOOL  = 4'd7,
    CMD_NULL  = 4'd8,
    CMD_ARRAY = 4'd9,
    CMD_MAP   = 4'd10,
    CMD_BREAK = 4'd11,
    CMD_RAW   = 4'd12
  } cmd_t;

  localparam int QDepth = 2;
  localparam int QIdxW = 1;

  // One classified item: head byte, argument bytes left aligned, byte count.
  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] body;
    logic [3:0]  count;
  } item_t;

  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    logic        s;
    logic [10:0] ex;
    logic [51:0] man;
    logic [52:0] m;
    logic [11:0] e;
    logic [11:0] shw;
    logic [6:0]  sh;
    logic [52:0] q;
    logic [52:0] rem;
    logic [52:0] half;
    logic [52:0] mask;
    logic [31:0] r;
    s = d[63];
    ex = d[62:52];
    man = d[51:0];
    m = {1'b1, man};
    e = {1'b0, ex} - 12'd896;
    r = {s, 31'd0};
    q = '0;
    sh = 7'd29;
    shw = '0;
    if (ex == 11'h7ff) begin
      r = (man == 52'd0) ? {s, 31'h7f800000} : {s, 8'hff, 1'b1, man[50:29]};
    end else if (ex == 11'd0) begin
      r = {s, 31'd0};
    end else if (!e[11] && e >= 12'd255) begin
      r = {s, 31'h7f800000};
    end else begin
      if (!e[11] && e != 12'd0) begin
        sh = 7'd29;
        q = {22'd0, e[7:0], man[51:29]};
      end else begin
        shw = 12'd30 - e;
        sh = (shw > 12'd60) ? 7'd61 : shw[6:0];
        q = (sh > 7'd60) ? 53'd0 : (m >> sh);
      end
      if (sh > 7'd60) begin
        r = {s, 31'd0};
      end else begin
        mask = (53'd1 << sh) - 53'd1;
        rem = m & mask;
        half = 53'd1 << (sh - 7'd1);
        if (rem > half || (rem == half && q[0])) begin
          q = q + 53'd1;
        end
        r = {s, q[30:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== design/cie_front.sv =====
// ----------------------------------------------------------------------------
// CBOR item encoder front end
// Classifies one input beat into a head byte, argument bytes and a count; queues it.
// ----------------------------------------------------------------------------
module cie_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             double_mode,
  input  logic             in_valid,
  input  logic [3:0]       command,
  input  logic [63:0]      value,
  output logic             in_stall,
  output logic             q_valid,
  output cie_pkg::item_t   q_item,
  input  logic             q_pop
);

  cie_pkg::item_t entry [cie_pkg::QDepth];
  logic [cie_pkg::QIdxW-1:0] wr_ptr;
  logic [cie_pkg::QIdxW-1:0] rd_ptr;
  logic [cie_pkg::QIdxW:0]   fill;
  cie_pkg::item_t cls;
  logic [63:0] arg;
  logic [2:0]  major;
  logic        is_head;
  logic [31:0] nf;
  logic        push;

  assign nf = cie_pkg::narrow_f64(value);

  always_comb begin
    cls = '0;
    arg = value;
    major = 3'd0;
    is_head = 1'b1;
    unique case (command)
      cie_pkg::CMD_UINT:  major = 3'd0;
      cie_pkg::CMD_SINT: begin
        if (value[63]) begin
          major = 3'd1;
          arg = ~value;
        end
      end
      cie_pkg::CMD_BYTES: major = 3'd2;
      cie_pkg::CMD_TEXT:  major = 3'd3;
      cie_pkg::CMD_TAG:   major = 3'd6;
      default: is_head = 1'b0;
    endcase
    if (is_head) begin
      if (arg < 64'd24) begin
        cls.head = {major, arg[4:0]};
        cls.count = 4'd1;
      end else if (arg <= 64'hff) begin
        cls.head = {major, 5'd24};
        cls.body = {arg[7:0], 56'd0};
        cls.count = 4'd2;
      end else if (arg <= 64'hffff) begin
        cls.head = {major, 5'd25};
        cls.body = {arg[15:0], 48'd0};
        cls.count = 4'd3;
      end else if (arg <= 64'hffffffff) begin
        cls.head = {major, 5'd26};
        cls.body = {arg[31:0], 32'd0};
        cls.count = 4'd5;
      end else begin
        cls.head = {major, 5'd27};
        cls.body = arg;
        cls.count = 4'd9;
      end
    end else begin
      unique case (command)
        cie_pkg::CMD_F32: begin
          cls.head = 8'hfa;
          cls.body = {value[31:0], 32'd0};
          cls.count = 4'd5;
        end
        cie_pkg::CMD_F64: begin
          if (double_mode) begin
            cls.head = 8'hfb;
            cls.body = value;
            cls.count = 4'd9;
          end else begin
            cls.head = 8'hfa;
            cls.body = {nf, 32'd0};
            cls.count = 4'd5;
          end
        end
        cie_pkg::CMD_BOOL: begin
          cls.head = value[0] ? 8'hf5 : 8'hf4;
          cls.count = 4'd1;
        end
        cie_pkg::CMD_NULL:  begin cls.head = 8'hf6; cls.count = 4'd1; end
        cie_pkg::CMD_ARRAY: begin cls.head = 8'h9f; cls.count = 4'd1; end
        cie_pkg::CMD_MAP:   begin cls.head = 8'hbf; cls.count = 4'd1; end
        cie_pkg::CMD_BREAK: begin cls.head = 8'hff; cls.count = 4'd1; end
        cie_pkg::CMD_RAW:   begin cls.head = value[7:0]; cls.count = 4'd1; end
        default: cls.count = 4'd0;
      endcase
    end
  end

  assign in_stall = (fill == (cie_pkg::QIdxW+1)'(cie_pkg::QDepth));
  assign push = in_valid && !in_stall && (cls.count != 4'd0);
  assign q_valid = (fill != '0);
  assign q_item = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end

endmodule

// ===== design/cie_back.sv =====
// ----------------------------------------------------------------------------
// CBOR item encoder back end
// Serializes a classified item into output beats, one byte each.
// ----------------------------------------------------------------------------
module cie_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cie_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           last_byte
);

  logic [63:0] sreg;
  logic [3:0]  left;
  logic        busy;
  logic        adv;
  logic        load;

  assign adv = out_valid && !out_stall;
  assign load = q_valid && (!busy || (adv && left == 4'd1));
  assign q_pop = load;
  assign out_valid = busy;
  assign last_byte = (left == 4'd1);

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= q_item.head;
      sreg <= q_item.body;
    end else if (adv) begin
      out_byte <= sreg[63:56];
      sreg <= {sreg[55:0], 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (load) begin
      busy <= 1'b1;
      left <= q_item.count;
    end else if (adv) begin
      left <= left - 4'd1;
      busy <= (left != 4'd1);
    end
  end

endmodule

// ===== design/cbor_item_encoder.sv =====
// ----------------------------------------------------------------------------
// CBOR item encoder
// Encodes one command and value per input beat into CBOR bytes.
// ----------------------------------------------------------------------------
// The input channel takes a command and a 64-bit value per beat under
// in_valid and in_stall. The output channel gives one byte per beat under
// out_valid and out_stall, with last_byte on the final byte of an item.
// Unused commands produce no bytes. double_mode is written through cfg_we.
// An item gives from one to nine output beats; an accepted item is first
// written into the queue and then loaded into the output register.
// Throughput is one byte per cycle while out_stall is low, set by the
// byte-wide output shift register. A two-entry queue sits between
// classifier and serializer, so new items are accepted while earlier
// bytes still wait. When the receiver stalls, the queue fills and in_stall
// rises. Synchronous reset empties the queue, drops the current item and
// sets double_mode to zero.
// ----------------------------------------------------------------------------
`include "cbor_item_encoder_defines.svh"

module cbor_item_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  command,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  logic           double_mode;
  logic           q_valid;
  logic           q_pop;
  cie_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_mode <= 1'b0;
    end else if (cfg_we) begin
      double_mode <= cfg_wdata;
    end
  end

  cie_front u_front (
    .clk(clk), .rst(rst), .double_mode(double_mode),
    .in_valid(in_valid), .command(command), .value(value), .in_stall(in_stall),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  cie_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last_byte(last_byte)
  );

  `CIE_ASSERT_IMPL(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  `CIE_ASSERT_NEXT(a_pop_shows, q_pop, out_valid, "popped item not shown")
  `CIE_ASSERT_IMPL(a_q_count, q_valid, q_item.count != 4'd0, "empty item queued")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// CBOR item encoder testbench
// Drives commands and values through the input channel, predicts the encoded
// byte stream of each item and checks every output beat against it, across
// both settings of double_mode and with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [63:0] val;
    int          nexp;
    logic [7:0]  first;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  command = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;

  enc_byte_t  pending_bytes[$];
  logic       dbl_mode = 1'b0;
  int         errors = 0;
  int         bytes_seen = 0;
  int         items_sent = 0;
  bit         calm = 1'b0;
  stim_row_t  directed[$];

  cbor_item_encoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last_byte(last_byte)
  );

  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("cbor_item_encoder verification failed");
    $finish;
  end

  function automatic logic [31:0] to_single(input logic [63:0] d);
    logic [10:0] ex;
    logic [51:0] man;
    logic [63:0] m, q, rem, half;
    int          e, sh;
    ex = d[62:52];
    man = d[51:0];
    if (ex == 11'h7ff) begin
      if (man == 0) return {d[63], 31'h7f800000};
      return {d[63], 8'hff, 1'b1, man[50:29]};
    end
    if (ex == 0) return {d[63], 31'd0};
    e = int'(ex) - 896;
    if (e >= 255) return {d[63], 31'h7f800000};
    m = {11'd0, 1'b1, man};
    if (e >= 1) begin
      sh = 29;
      q = (64'(e) << 23) + (man >> 29);
    end else begin
      sh = 30 - e;
      if (sh > 60) return {d[63], 31'd0};
      q = m >> sh;
    end
    rem = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return {d[63], q[30:0]};
  endfunction

  function automatic int encode_item(input logic [3:0] cmd, input logic [63:0] v,
                                     output logic [7:0] b[9]);
    logic [7:0]  major;
    logic [63:0] arg, body;
    int          nb;
    nb = 0;
    body = '0;
    for (int i = 0; i < 9; i++) b[i] = '0;
    case (cmd)
      cie_pkg::CMD_UINT, cie_pkg::CMD_SINT, cie_pkg::CMD_BYTES, cie_pkg::CMD_TEXT,
      cie_pkg::CMD_TAG: begin
        arg = v;
        major = 8'h00;
        if (cmd == cie_pkg::CMD_SINT && v[63]) begin
          arg = ~v;
          major = 8'h20;
        end
        if (cmd == cie_pkg::CMD_BYTES) major = 8'h40;
        if (cmd == cie_pkg::CMD_TEXT) major = 8'h60;
        if (cmd == cie_pkg::CMD_TAG) major = 8'hc0;
        if (arg < 24) b[0] = major + arg[7:0];
        else if (arg <= 64'hff) begin b[0] = major + 24; nb = 1; end
        else if (arg <= 64'hffff) begin b[0] = major + 25; nb = 2; end
        else if (arg <= 64'hffffffff) begin b[0] = major + 26; nb = 4; end
        else begin b[0] = major + 27; nb = 8; end
        body = arg;
      end
      cie_pkg::CMD_F32: begin b[0] = 8'hfa; nb = 4; body = {32'd0, v[31:0]}; end
      cie_pkg::CMD_F64: begin
        if (dbl_mode) begin b[0] = 8'hfb; nb = 8; body = v; end
        else begin b[0] = 8'hfa; nb = 4; body = {32'd0, to_single(v)}; end
      end
      cie_pkg::CMD_BOOL:  b[0] = v[0] ? 8'hf5 : 8'hf4;
      cie_pkg::CMD_NULL:  b[0] = 8'hf6;
      cie_pkg::CMD_ARRAY: b[0] = 8'h9f;
      cie_pkg::CMD_MAP:   b[0] = 8'hbf;
      cie_pkg::CMD_BREAK: b[0] = 8'hff;
      cie_pkg::CMD_RAW:   b[0] = v[7:0];
      default:   return 0;
    endcase
    for (int i = 0; i < nb; i++) b[1 + i] = body[8 * (nb - 1 - i) +: 8];
    return nb + 1;
  endfunction

  task automatic send_item(input logic [3:0] cmd, input logic [63:0] v,
                           input int nexp, input logic [7:0] first);
    logic [7:0] b[9];
    int         n;
    enc_byte_t  eb;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    n = encode_item(cmd, v, b);
    if (nexp >= 0 && (n != nexp || (n > 0 && b[0] != first))) begin
      $error("directed row cmd %0d: count exp %0d act %0d, head exp %0h act %0h",
             cmd, nexp, n, first, b[0]);
      errors++;
    end
    for (int i = 0; i < n; i++) begin
      eb.data = b[i];
      eb.last = (i == n - 1);
      pending_bytes = {pending_bytes, eb};
    end
    in_valid <= 1'b1;
    command <= cmd;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic set_mode(input logic m);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    dbl_mode = m;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        bytes_seen++;
        if (pending_bytes.size() == 0) begin
          $error("unexpected beat: out_byte %0h last_byte %0b", out_byte, last_byte);
          errors++;
        end else begin
          if (out_byte !== pending_bytes[0].data) begin
            $error("out_byte exp %0h act %0h", pending_bytes[0].data, out_byte);
            errors++;
          end
          if (last_byte !== pending_bytes[0].last) begin
            $error("last_byte exp %0b act %0b", pending_bytes[0].last, last_byte);
            errors++;
          end
          void'(pending_bytes.pop_front());
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_value(input logic [3:0] cmd);
    int s;
    s = $urandom_range(5);
    if (cmd == cie_pkg::CMD_F64 && $urandom_range(2) == 0) begin
      return {1'($urandom_range(1)), 11'(($urandom_range(1) ? 11'h7ff : 11'(1023 +
              int'($urandom_range(320)) - 170))), 52'(rand64())};
    end
    case (s)
      0: return 64'($urandom_range(30));
      1: return 64'($urandom_range(300));
      2: return 64'($urandom_range(70000));
      3: return 64'($urandom());
      4: return ~64'($urandom_range(300));
      default: return rand64();
    endcase
  endfunction

  task automatic add_row(input logic [3:0] c, input logic [63:0] v, input int n,
                         input logic [7:0] f);
    stim_row_t r;
    r.cmd = c; r.val = v; r.nexp = n; r.first = f;
    directed = {directed, r};
  endtask

  initial begin
    logic [3:0] c;
    add_row(cie_pkg::CMD_UINT, 64'd0, 1, 8'h00);
    add_row(cie_pkg::CMD_UINT, 64'd23, 1, 8'h17);
    add_row(cie_pkg::CMD_UINT, 64'd24, 2, 8'h18);
    add_row(cie_pkg::CMD_UINT, 64'hffff_ffff_ffff_ffff, 9, 8'h1b);
    add_row(cie_pkg::CMD_SINT, 64'h8000_0000_0000_0000, 9, 8'h3b);
    add_row(cie_pkg::CMD_SINT, 64'hffff_ffff_ffff_ffff, 1, 8'h20);
    add_row(cie_pkg::CMD_BYTES, 64'h100, 3, 8'h59);
    add_row(cie_pkg::CMD_TEXT, 64'h1_0000, 5, 8'h7a);
    add_row(cie_pkg::CMD_TAG, 64'd55799, 3, 8'hd9);
    add_row(cie_pkg::CMD_F32, 64'hffff_ffff_3f80_0000, 5, 8'hfa);
    add_row(cie_pkg::CMD_F64, 64'h7ff8_0000_0000_0001, -1, 0);
    add_row(cie_pkg::CMD_F64, 64'hfff0_0000_0000_0000, -1, 0);
    add_row(cie_pkg::CMD_F64, 64'h47f0_0000_0000_0000, -1, 0);
    add_row(cie_pkg::CMD_F64, 64'h3690_0000_0000_0000, -1, 0);
    add_row(cie_pkg::CMD_F64, 64'h8000_0000_0000_0001, -1, 0);
    add_row(cie_pkg::CMD_F64, 64'h3ff0_0000_1000_0000, -1, 0);
    add_row(cie_pkg::CMD_BOOL, 64'hffff_ffff_ffff_fffe, 1, 8'hf4);
    add_row(cie_pkg::CMD_BOOL, 64'd1, 1, 8'hf5);
    add_row(cie_pkg::CMD_NULL, 64'd0, 1, 8'hf6);
    add_row(cie_pkg::CMD_ARRAY, 64'd0, 1, 8'h9f);
    add_row(cie_pkg::CMD_MAP, 64'd0, 1, 8'hbf);
    add_row(cie_pkg::CMD_BREAK, 64'd0, 1, 8'hff);
    add_row(cie_pkg::CMD_RAW, 64'hffff_ffff_ffff_ff5a, 1, 8'h5a);
    add_row(4'd13, 64'd7, 0, 0);
    add_row(4'd15, 64'hffff_ffff_ffff_ffff, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].val, directed[i].nexp, directed[i].first);
    set_mode(1'b1);
    for (int i = 10; i <= 15; i++)
      send_item(directed[i].cmd, directed[i].val, -1, 0);
    for (int i = 0; i < 480; i++) begin
      if (i == 120) set_mode(1'b0);
      if (i == 240) set_mode(1'b1);
      if (i == 360) set_mode(1'b0);
      calm = (i >= 300 && i < 340);
      if (i == 200) begin
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
      end
      c = ($urandom_range(19) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(12));
      send_item(c, pick_value(c), -1, 0);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items over both float modes; checked %0d output bytes.",
             items_sent, bytes_seen);
    if (errors == 0) begin
      $display("cbor_item_encoder verification clean");
    end else begin
      $display("cbor_item_encoder verification failed");
    end
    $finish;
  end
endmodule
